@@ rtl/slp_pkg.sv @@
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and constants for the string literal lexer.
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int unsigned MAX_TOKEN_LENGTH_DEF = 32'd65535;

    localparam int CP_W  = 21;
    localparam int LEN_W = 16;

    // Characters of interest
    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_U      = 21'h75;
    localparam logic [CP_W-1:0] CH_8      = 21'h38;
    localparam logic [CP_W-1:0] CH_1      = 21'h31;
    localparam logic [CP_W-1:0] CH_6      = 21'h36;
    localparam logic [CP_W-1:0] CH_3      = 21'h33;
    localparam logic [CP_W-1:0] CH_2      = 21'h32;

    // Literal kind codes
    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_U8      = 2'd1;
    localparam logic [1:0] KIND_U16     = 2'd2;
    localparam logic [1:0] KIND_U32     = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED   = 2'd1;
    localparam logic [1:0] ERR_BAD_SUFFIX = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG   = 2'd3;

    // SUF1..SUF4: first to fourth character after the closing quote
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_SUF1,
        PH_SUF2,
        PH_SUF3,
        PH_SUF4
    } t_phase;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            scan_start;
        logic            source_end;
    } t_item;

    typedef struct packed {
        logic             accepted;
        logic [1:0]       literal_kind;
        logic [LEN_W-1:0] token_length;
        logic [1:0]       error_code;
    } t_verdict;

endpackage

@@ rtl/slp_core.sv @@
// ----------------------------------------------------------------------------
// slp_core
// Scan state and verdict logic: one character per step.
// ----------------------------------------------------------------------------
module slp_core #(
    parameter int unsigned MAX_TOKEN_LENGTH = slp_pkg::MAX_TOKEN_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  slp_pkg::t_item    i_item,
    output logic              o_fire,
    output slp_pkg::t_verdict o_verdict
);

    localparam int unsigned BOUND_I = (MAX_TOKEN_LENGTH < 32'd65535) ?
                                      MAX_TOKEN_LENGTH : 32'd65535;
    localparam logic [slp_pkg::LEN_W:0] BOUND = (slp_pkg::LEN_W+1)'(BOUND_I);

    slp_pkg::t_phase               r_phase, n_phase;
    logic [slp_pkg::LEN_W-1:0]     r_count, n_count;
    logic                          r_bslash, n_bslash;
    logic [slp_pkg::CP_W-1:0]      r_suf1, n_suf1;
    logic [slp_pkg::CP_W-1:0]      r_suf2, n_suf2;

    logic                          fire;
    logic                          acc;
    logic [1:0]                    kind;
    logic [1:0]                    err;
    logic [slp_pkg::LEN_W:0]       len;
    logic [slp_pkg::LEN_W:0]       cnt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= slp_pkg::PH_IDLE;
            r_count  <= '0;
            r_bslash <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_bslash <= n_bslash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_suf1 <= n_suf1;
            r_suf2 <= n_suf2;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_bslash = r_bslash;
        n_suf1   = r_suf1;
        n_suf2   = r_suf2;
        fire     = 1'b0;
        acc      = 1'b0;
        kind     = slp_pkg::KIND_DEFAULT;
        err      = slp_pkg::ERR_NONE;
        len      = '0;
        cnt_ext  = {1'b0, r_count};

        if (i_item.scan_start) begin
            if (i_item.code_point != slp_pkg::CH_QUOTE || i_item.source_end) begin
                fire    = 1'b1;
                n_phase = slp_pkg::PH_IDLE;
            end else begin
                n_phase  = slp_pkg::PH_BODY;
                n_count  = (slp_pkg::LEN_W)'(1);
                n_bslash = 1'b0;
            end
        end else begin
            unique case (r_phase)
                slp_pkg::PH_BODY: begin
                    if (i_item.code_point == slp_pkg::CH_QUOTE && !r_bslash) begin
                        // r_count now holds the closing quote's offset
                        if (i_item.source_end) begin
                            fire    = 1'b1;
                            acc     = 1'b1;
                            len     = cnt_ext + 17'd1;
                            n_phase = slp_pkg::PH_IDLE;
                        end else begin
                            n_phase = slp_pkg::PH_SUF1;
                        end
                    end else begin
                        n_bslash = (i_item.code_point == slp_pkg::CH_BSLASH);
                        n_count  = r_count + 1'b1;
                        if (i_item.source_end) begin
                            fire    = 1'b1;
                            err     = slp_pkg::ERR_UNCLOSED;
                            n_phase = slp_pkg::PH_IDLE;
                        end else if (cnt_ext + 17'd1 >= BOUND) begin
                            fire    = 1'b1;
                            err     = slp_pkg::ERR_TOO_LONG;
                            n_phase = slp_pkg::PH_IDLE;
                        end
                    end
                end
                slp_pkg::PH_SUF1: begin
                    if (i_item.source_end || i_item.code_point != slp_pkg::CH_U) begin
                        fire    = 1'b1;
                        acc     = 1'b1;
                        len     = cnt_ext + 17'd1;
                        n_phase = slp_pkg::PH_IDLE;
                    end else begin
                        n_phase = slp_pkg::PH_SUF2;
                    end
                end
                slp_pkg::PH_SUF2: begin
                    n_suf1 = i_item.code_point;
                    if (i_item.source_end) begin
                        fire    = 1'b1;
                        acc     = 1'b1;
                        len     = cnt_ext + 17'd1;
                        n_phase = slp_pkg::PH_IDLE;
                    end else begin
                        n_phase = slp_pkg::PH_SUF3;
                    end
                end
                slp_pkg::PH_SUF3: begin
                    n_suf2 = i_item.code_point;
                    if (r_suf1 == slp_pkg::CH_8) begin
                        fire    = 1'b1;
                        acc     = 1'b1;
                        kind    = slp_pkg::KIND_U8;
                        len     = cnt_ext + 17'd3;
                        n_phase = slp_pkg::PH_IDLE;
                    end else if (i_item.source_end) begin
                        fire    = 1'b1;
                        err     = slp_pkg::ERR_BAD_SUFFIX;
                        n_phase = slp_pkg::PH_IDLE;
                    end else begin
                        n_phase = slp_pkg::PH_SUF4;
                    end
                end
                slp_pkg::PH_SUF4: begin
                    fire    = 1'b1;
                    n_phase = slp_pkg::PH_IDLE;
                    if (r_suf1 == slp_pkg::CH_1 && r_suf2 == slp_pkg::CH_6) begin
                        acc  = 1'b1;
                        kind = slp_pkg::KIND_U16;
                        len  = cnt_ext + 17'd4;
                    end else if (r_suf1 == slp_pkg::CH_3 && r_suf2 == slp_pkg::CH_2) begin
                        acc  = 1'b1;
                        kind = slp_pkg::KIND_U32;
                        len  = cnt_ext + 17'd4;
                    end else begin
                        err = slp_pkg::ERR_BAD_SUFFIX;
                    end
                end
                default: begin
                    n_phase = slp_pkg::PH_IDLE;
                end
            endcase
        end

        // suffix may push a closed token past the bound
        if (acc && len > BOUND) begin
            acc = 1'b0;
            err = slp_pkg::ERR_TOO_LONG;
        end
        if (!acc) begin
            kind = slp_pkg::KIND_DEFAULT;
            len  = '0;
        end
    end

    assign o_fire                 = fire;
    assign o_verdict.accepted     = acc;
    assign o_verdict.literal_kind = kind;
    assign o_verdict.token_length = len[slp_pkg::LEN_W-1:0];
    assign o_verdict.error_code   = err;

`ifndef SYNTHESIS
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && acc) |-> (err == slp_pkg::ERR_NONE && len >= 17'd2 && len <= BOUND))
        else $error("accepted verdict with error or bad length");

    a_rej_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !acc) |-> (kind == slp_pkg::KIND_DEFAULT && len == '0))
        else $error("rejected verdict carries kind or length");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != slp_pkg::PH_IDLE) |-> (r_count != '0 && {1'b0, r_count} < BOUND))
        else $error("scan count out of range");
`endif

endmodule

@@ rtl/string_literal_lexer.sv @@
// ----------------------------------------------------------------------------
// string_literal_lexer
// Double-quoted string literal recognizer with u8/u16/u32 suffix check.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one code point per transfer
// with scan start and source end marks. A quote marked as scan start and not
// as source end opens a scan that yields exactly one verdict, unless a new
// scan start cuts it off; any other scan-start character is rejected at once.
// The output channel (o_out_valid / i_out_ready) carries accepted flag,
// literal kind, token length and error code. Unmarked characters outside a
// scan give no transfer on the output.
// A character taken waits in the input register, then passes through the scan
// state update and verdict logic; any verdict goes into the result register.
// Throughput: one character per cycle while the input register can advance.
// When the receiver stalls, the result register holds its verdict; the input
// register still advances characters that give no verdict, and stops only
// when the next verdict has nowhere to go.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// scan to idle.
// ----------------------------------------------------------------------------
module string_literal_lexer #(
    parameter int unsigned MAX_TOKEN_LENGTH = slp_pkg::MAX_TOKEN_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [slp_pkg::CP_W-1:0]    i_code_point,
    input  logic                        i_scan_start,
    input  logic                        i_source_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_accepted,
    output logic [1:0]                  o_literal_kind,
    output logic [slp_pkg::LEN_W-1:0]   o_token_length,
    output logic [1:0]                  o_error_code
);

    logic              r_in_valid;
    slp_pkg::t_item    r_in;
    logic              r_out_valid;
    slp_pkg::t_verdict r_out;

    logic              fire;
    slp_pkg::t_verdict verdict;
    logic              out_free;
    logic              advance;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!fire || out_free);
    assign o_in_ready = !r_in_valid || advance;

    slp_core #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_item    (r_in),
        .o_fire    (fire),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.code_point <= i_code_point;
            r_in.scan_start <= i_scan_start;
            r_in.source_end <= i_source_end;
        end
        if (advance && fire) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out.accepted;
    assign o_literal_kind = r_out.literal_kind;
    assign o_token_length = r_out.token_length;
    assign o_error_code   = r_out.error_code;

endmodule
